// File: design/rfr_pkg.sv
// Shared constants and types for the radio frame receiver.
// Depends on nothing; imported by the receiver top level.
package rfr_pkg;

	typedef logic [7:0] byte_t;

	localparam int RING_DEPTH = 256;
	localparam int MSG_DEPTH  = 128;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int MSG_AW     = $clog2(MSG_DEPTH);
	localparam int LEN_W      = MSG_AW + 1;

	// backward header scan reads newest+2 down to newest-(depth-1)
	localparam int SCAN_READS = RING_DEPTH + 2;
	localparam int CNT_MAX    = (SCAN_READS > MSG_DEPTH) ? SCAN_READS : MSG_DEPTH;
	localparam int CNT_W      = $clog2(CNT_MAX + 1);
	localparam int ACC_W      = 10;

	localparam int HDR_LEN_OFS  = 6;
	localparam int HDR_DATA_OFS = 9;
	localparam int LEN_DIGITS   = 3;

	localparam byte_t CH_R  = 8'h52;
	localparam byte_t CH_B  = 8'h42;
	localparam byte_t CH_N  = 8'h4E;
	localparam byte_t CH_CR = 8'h0D;
	localparam byte_t CH_LF = 8'h0A;
	localparam byte_t CH_0  = 8'h30;
	localparam byte_t CH_9  = 8'h39;

	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam byte_t LIMIT_RESET = 8'd10;

endpackage

// File: design/rfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/radio_frame_receiver.sv
// Radio frame receiver: ring buffer of received bytes, header scan and message copy.
// Depends on rfr_pkg and rfr_ram.
//
// One input word is taken at a time. A timer tick, action 3 and a received byte that does
// not end in CR LF finish in the cycle they are accepted; a message read finishes after
// one message RAM read in the ST_RDM state. A byte that completes CR LF starts a walk over
// the ring RAM, one read per cycle through its single read port: a backward scan of up to
// RING_DEPTH+2 reads for the newest "RBN" header, three reads for the length digits, one
// check state, then one read per message byte copied. Both RAMs start out zero by tracking
// how far they were filled, so no clearing pass runs after reset. The result waits in an
// output register; the next word is taken once the receiver is idle and that register is
// empty or being drained.
module radio_frame_receiver
	import rfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,    // timeout_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // rx_byte[7:0], read_index[14:8], zero[15]
	input  logic [1:0]  s_tuser,     // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // message_length[7:0], read_data[15:8], link_ok[16], zero
	output logic [1:0]  m_tuser      // frame_done[0], frame_error[1]
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIG  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_COPY = 3'd4;
	localparam logic [2:0] ST_RDM  = 3'd5;

	// control state
	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RING_AW-1:0] wp_q;
	logic [RING_AW:0]   ring_fill_q;
	logic [LEN_W-1:0]   msg_hw_q;
	logic [LEN_W-1:0]   stored_len_q;
	byte_t              prev_q;
	byte_t              idle_q;
	byte_t              limit_q;
	logic               link_q;
	logic               out_vld_q;
	logic               rvld_s1;
	logic [2:0]         rst_s1;
	logic [CNT_W-1:0]   rk_s1;

	// payload registers
	logic [RING_AW-1:0] raddr_s1;
	logic [RING_AW-1:0] base_q;
	logic [RING_AW-1:0] hp_q;
	byte_t              b1_q;
	byte_t              b2_q;
	logic [ACC_W-1:0]   acc_q;
	logic               dok_q;
	logic [LEN_W-1:0]   len_q;
	logic               clamp_q;
	logic               rd_ok_s1;
	logic               out_done_q;
	logic               out_err_q;
	byte_t              out_len_q;
	byte_t              out_rdata_q;
	logic               out_link_q;

	// datapath
	logic               accept;
	logic [1:0]         action;
	byte_t              rx_byte;
	logic [MSG_AW+6:0]  ridx_ext;
	logic [MSG_AW-1:0]  ridx;
	logic               crlf;
	logic               issue;
	logic [RING_AW-1:0] issue_addr;
	byte_t              ring_rdata;
	byte_t              ring_byte;
	logic               rsp;
	logic               match;
	logic               scan_end;
	logic               is_dig;
	logic               dig_last;
	logic               copy_last;
	logic               chk_clamp;
	logic [LEN_W-1:0]   chk_len;
	logic               msg_we;
	byte_t              msg_rdata;
	logic               fin;
	logic               fin_done;
	logic               fin_err;
	byte_t              fin_rdata;
	logic [LEN_W-1:0]   stored_len_d;
	logic [LEN_W+7:0]   len_ext;
	logic               link_d;
	byte_t              idle_d;

	assign cfg_ready = 1'b1;
	assign action    = s_tuser;
	assign rx_byte   = s_tdata[7:0];
	assign ridx_ext  = (MSG_AW + 7)'(s_tdata[14:8]);
	assign ridx      = ridx_ext[MSG_AW-1:0];
	assign s_tready  = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign crlf      = (prev_q == CH_CR) && (rx_byte == CH_LF);

	// ring read sequencing
	always_comb begin
		issue      = 1'b0;
		issue_addr = '0;
		case (state_q)
			ST_SCAN: begin
				issue      = cnt_q < CNT_W'(SCAN_READS);
				issue_addr = base_q + RING_AW'(2) - cnt_q[RING_AW-1:0];
			end
			ST_DIG: begin
				issue      = cnt_q < CNT_W'(LEN_DIGITS);
				issue_addr = hp_q + RING_AW'(HDR_LEN_OFS) + cnt_q[RING_AW-1:0];
			end
			ST_COPY: begin
				issue      = cnt_q < CNT_W'(len_q);
				issue_addr = hp_q + RING_AW'(HDR_DATA_OFS) + cnt_q[RING_AW-1:0];
			end
			default: begin
				issue      = 1'b0;
				issue_addr = '0;
			end
		endcase
	end

	rfr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
		.clk     (clk),
		.wr_en   (accept && (action == ACT_BYTE)),
		.wr_addr (wp_q),
		.wr_data (rx_byte),
		.rd_en   (issue),
		.rd_addr (issue_addr),
		.rd_data (ring_rdata)
	);

	// drop responses issued in an earlier phase
	assign rsp       = rvld_s1 && (rst_s1 == state_q);
	assign ring_byte = ({1'b0, raddr_s1} < ring_fill_q) ? ring_rdata : 8'h00;
	assign match     = rsp && (state_q == ST_SCAN) && (rk_s1 >= CNT_W'(2)) &&
	                   (ring_byte == CH_R) && (b1_q == CH_B) && (b2_q == CH_N);
	assign scan_end  = rsp && (state_q == ST_SCAN) && !match &&
	                   (rk_s1 == CNT_W'(SCAN_READS - 1));
	assign is_dig    = (ring_byte >= CH_0) && (ring_byte <= CH_9);
	assign dig_last  = rsp && (state_q == ST_DIG) && (rk_s1 == CNT_W'(LEN_DIGITS - 1));
	assign copy_last = rsp && (state_q == ST_COPY) && (rk_s1 == CNT_W'(len_q) - 1'b1);
	assign chk_clamp = 32'(acc_q) > 32'(MSG_DEPTH);
	assign chk_len   = chk_clamp ? LEN_W'(MSG_DEPTH) : LEN_W'(acc_q);
	assign msg_we    = rsp && (state_q == ST_COPY);

	rfr_ram #(.WIDTH(8), .DEPTH(MSG_DEPTH)) u_msg (
		.clk     (clk),
		.wr_en   (msg_we),
		.wr_addr (rk_s1[MSG_AW-1:0]),
		.wr_data (ring_byte),
		.rd_en   (accept && (action == ACT_READ)),
		.rd_addr (ridx),
		.rd_data (msg_rdata)
	);

	// link timeout
	always_comb begin
		link_d = link_q;
		idle_d = idle_q;
		if (accept && (action == ACT_BYTE)) begin
			idle_d = 8'd0;
		end else if (accept && (action == ACT_TICK)) begin
			if (idle_q >= limit_q) begin
				link_d = 1'b0;
			end else begin
				link_d = 1'b1;
				idle_d = idle_q + 8'd1;
			end
		end
	end

	// result assembly
	always_comb begin
		fin          = 1'b0;
		fin_done     = 1'b0;
		fin_err      = 1'b0;
		fin_rdata    = 8'h00;
		stored_len_d = stored_len_q;
		if (accept && (action != ACT_READ) && !((action == ACT_BYTE) && crlf)) begin
			fin = 1'b1;
		end
		if (scan_end) begin
			fin = 1'b1;
		end
		if (state_q == ST_CHK) begin
			if (!dok_q) begin
				fin      = 1'b1;
				fin_done = 1'b1;
				fin_err  = 1'b1;
			end else begin
				stored_len_d = chk_len;
				if (chk_len == '0) begin
					fin      = 1'b1;
					fin_done = 1'b1;
					fin_err  = chk_clamp;
				end
			end
		end
		if (copy_last) begin
			fin      = 1'b1;
			fin_done = 1'b1;
			fin_err  = clamp_q;
		end
		if (state_q == ST_RDM) begin
			fin       = 1'b1;
			fin_rdata = rd_ok_s1 ? msg_rdata : 8'h00;
		end
	end

	assign len_ext = (LEN_W + 8)'(stored_len_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			wp_q         <= '0;
			ring_fill_q  <= '0;
			msg_hw_q     <= '0;
			stored_len_q <= '0;
			prev_q       <= 8'h00;
			idle_q       <= LIMIT_RESET;
			limit_q      <= LIMIT_RESET;
			link_q       <= 1'b0;
			out_vld_q    <= 1'b0;
			rvld_s1      <= 1'b0;
			rst_s1       <= ST_IDLE;
			rk_s1        <= '0;
		end else begin
			rvld_s1      <= issue;
			rst_s1       <= state_q;
			rk_s1        <= cnt_q;
			link_q       <= link_d;
			idle_q       <= idle_d;
			stored_len_q <= stored_len_d;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (fin) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (action == ACT_BYTE)) begin
						wp_q   <= wp_q + 1'b1;
						prev_q <= rx_byte;
						if (ring_fill_q != (RING_AW + 1)'(RING_DEPTH)) begin
							ring_fill_q <= ring_fill_q + 1'b1;
						end
						if (crlf) begin
							state_q <= ST_SCAN;
							cnt_q   <= '0;
						end
					end else if (accept && (action == ACT_READ)) begin
						state_q <= ST_RDM;
					end
				end
				ST_SCAN: begin
					if (match) begin
						state_q <= ST_DIG;
						cnt_q   <= '0;
					end else if (scan_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIG: begin
					if (dig_last) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (!dok_q) begin
						state_q <= ST_IDLE;
					end else begin
						if (chk_len > msg_hw_q) begin
							msg_hw_q <= chk_len;
						end
						cnt_q   <= '0;
						state_q <= (chk_len == '0) ? ST_IDLE : ST_COPY;
					end
				end
				ST_COPY: begin
					if (copy_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDM: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= issue_addr;
		if (accept) begin
			base_q   <= wp_q;
			rd_ok_s1 <= {1'b0, ridx} < msg_hw_q;
		end
		if (rsp) begin
			b2_q <= b1_q;
			b1_q <= ring_byte;
		end
		if (match) begin
			hp_q  <= raddr_s1;
			acc_q <= '0;
			dok_q <= 1'b1;
		end
		if (rsp && (state_q == ST_DIG)) begin
			acc_q <= ACC_W'(acc_q * ACC_W'(10)) + ACC_W'(ring_byte - CH_0);
			dok_q <= dok_q && is_dig;
		end
		if (state_q == ST_CHK) begin
			len_q   <= chk_len;
			clamp_q <= chk_clamp;
		end
		if (fin) begin
			out_done_q  <= fin_done;
			out_err_q   <= fin_err;
			out_len_q   <= len_ext[7:0];
			out_rdata_q <= fin_rdata;
			out_link_q  <= link_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_link_q, out_rdata_q, out_len_q};
	assign m_tuser  = {out_err_q, out_done_q};

	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_vld_q || m_tready))
		else $error("result produced while output register is held");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken while a frame walk is in progress");

	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_BYTE)) |=> (wp_q == RING_AW'($past(wp_q) + 1'b1)))
		else $error("write position did not advance after a byte");

	a_copy_range: assert property (@(posedge clk) disable iff (!arst_n)
		msg_we |-> (rk_s1 < CNT_W'(len_q)) && (len_q <= LEN_W'(MSG_DEPTH)))
		else $error("message copy beyond parsed length");

	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && fin_err) |-> fin_done)
		else $error("frame error flagged without a parse");

endmodule

// File: test/radio_frame_receiver_test.sv
// Self-checking testbench for radio_frame_receiver: a directed table of expected results, then random
// frames, ticks and reads, each result compared with an in-bench model of ring, parser and timeout.
// Depends on rfr_pkg and the receiver RTL.
module radio_frame_receiver_test
	import rfr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 40;
	localparam int DRAIN_CYCLES = 420;

	typedef struct packed {
		logic  done;
		logic  err;
		byte_t len;
		byte_t rdata;
		logic  link;
	} frame_result_t;

	typedef struct packed {
		logic [1:0]    act;
		byte_t         data;
		logic [6:0]    idx;
		logic          typed;
		frame_result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic [1:0]  s_tuser = 2'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	// receiver model state
	byte_t ring [RING_DEPTH];
	byte_t msg [MSG_DEPTH];
	int    wpos;
	int    msg_len;
	byte_t idle_ticks;
	logic  link_flag;
	byte_t limit;

	frame_result_t expected_results[$];
	int errors = 0;
	int words_sent = 0;
	int frames_parsed = 0;
	int frames_flagged = 0;
	int link_drops = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit long_burst_done = 0;

	// directed table: reset state, no-header CR LF, header with bad digits, clamped length
	stim_row_t directed [21] = '{
		'{ACT_READ, 8'h00, 7'd127, 1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_TICK, 8'h00, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_NONE, 8'hFF, 7'd127, 1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, 8'h00, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_CR, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_LF, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_R,  7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_B,  7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_N,  7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_CR, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_LF, 7'd0,   1'b1, '{1'b1, 1'b1, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, 8'hFF, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_9,  7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_9,  7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_9,  7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_CR, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00, 1'b0}},
		'{ACT_BYTE, CH_LF, 7'd0,   1'b1, '{1'b1, 1'b1, 8'd128, 8'h00, 1'b0}},
		'{ACT_READ, 8'h00, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd128, 8'h0D, 1'b0}},
		'{ACT_READ, 8'h00, 7'd127, 1'b1, '{1'b0, 1'b0, 8'd128, 8'h00, 1'b0}},
		'{ACT_TICK, 8'h00, 7'd0,   1'b1, '{1'b0, 1'b0, 8'd128, 8'h00, 1'b1}},
		'{ACT_READ, 8'hFF, 7'd1,   1'b1, '{1'b0, 1'b0, 8'd128, 8'h0A, 1'b1}}
	};

	radio_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Advance the model by one word and return the result it produces.
	function automatic frame_result_t predict_receiver(logic [1:0] act, byte_t data,
			logic [6:0] idx);
		frame_result_t r;
		byte_t prev;
		byte_t dig [3];
		int hp;
		int len;
		bit found;
		r = '0;
		case (act)
			ACT_BYTE: begin
				prev = ring[(wpos + RING_DEPTH - 1) % RING_DEPTH];
				ring[wpos] = data;
				idle_ticks = 8'd0;
				if (prev == CH_CR && data == CH_LF) begin
					found = 1'b0;
					for (int back = 0; back < RING_DEPTH && !found; back++) begin
						hp = (wpos + RING_DEPTH - back) % RING_DEPTH;
						if (ring[hp] == CH_R && ring[(hp + 1) % RING_DEPTH] == CH_B &&
								ring[(hp + 2) % RING_DEPTH] == CH_N) begin
							found = 1'b1;
							r.done = 1'b1;
							frames_parsed++;
							for (int k = 0; k < 3; k++)
								dig[k] = ring[(hp + HDR_LEN_OFS + k) % RING_DEPTH];
							if (dig[0] < CH_0 || dig[0] > CH_9 || dig[1] < CH_0 ||
									dig[1] > CH_9 || dig[2] < CH_0 || dig[2] > CH_9) begin
								r.err = 1'b1;
							end else begin
								len = (dig[0] - CH_0) * 100 + (dig[1] - CH_0) * 10 +
									(dig[2] - CH_0);
								if (len > MSG_DEPTH) begin
									len = MSG_DEPTH;
									r.err = 1'b1;
								end
								for (int k = 0; k < len; k++)
									msg[k] = ring[(hp + HDR_DATA_OFS + k) % RING_DEPTH];
								msg_len = len;
							end
							if (r.err)
								frames_flagged++;
						end
					end
				end
				wpos = (wpos + 1) % RING_DEPTH;
			end
			ACT_TICK: begin
				if (idle_ticks >= limit) begin
					if (link_flag)
						link_drops++;
					link_flag = 1'b0;
				end else begin
					link_flag = 1'b1;
					idle_ticks = idle_ticks + 8'd1;
				end
			end
			ACT_READ: r.rdata = msg[idx];
			default: ;
		endcase
		r.len = msg_len[7:0];
		r.link = link_flag;
		return r;
	endfunction

	// Offer one word, hold it until taken, then log its expected result.
	task automatic send_word(logic [1:0] act, byte_t data, logic [6:0] idx,
			logic typed = 1'b0, frame_result_t want = '0);
		frame_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, idx, data};
		s_tuser <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_receiver(act, data, idx);
		expected_results.push_back(typed ? want : r);
		if (act != ACT_NONE)
			words_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(byte_t value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		limit = value;
	endtask

	// Noise, header, filler, length digits (sometimes broken or too large), payload, CR LF.
	task automatic send_random_frame();
		int len;
		int pick;
		int payload;
		byte_t dig [3];
		byte_t c;
		repeat ($urandom_range(0, 3))
			send_word(ACT_BYTE, byte_t'($urandom_range(255)), 7'd0);
		send_word(ACT_BYTE, CH_R, 7'd0);
		send_word(ACT_BYTE, CH_B, 7'd0);
		send_word(ACT_BYTE, CH_N, 7'd0);
		repeat (3)
			send_word(ACT_BYTE, byte_t'($urandom_range(255)), 7'd0);
		pick = $urandom_range(99);
		if (pick < 70)
			len = $urandom_range(0, 24);
		else if (pick < 82)
			len = $urandom_range(25, MSG_DEPTH);
		else
			len = $urandom_range(MSG_DEPTH + 1, 999);
		dig[0] = CH_0 + byte_t'(len / 100);
		dig[1] = CH_0 + byte_t'((len / 10) % 10);
		dig[2] = CH_0 + byte_t'(len % 10);
		payload = (len <= MSG_DEPTH) ? len : $urandom_range(0, 8);
		if (pick >= 90) begin
			c = byte_t'($urandom_range(255));
			while (c >= CH_0 && c <= CH_9)
				c = byte_t'($urandom_range(255));
			dig[$urandom_range(2)] = c;
			payload = $urandom_range(0, 8);
		end
		for (int k = 0; k < 3; k++)
			send_word(ACT_BYTE, dig[k], 7'd0);
		repeat (payload)
			send_word(ACT_BYTE, byte_t'($urandom_range(255)), 7'd0);
		send_word(ACT_BYTE, CH_CR, 7'd0);
		send_word(ACT_BYTE, CH_LF, 7'd0);
	endtask

	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: tuser %b tdata %h", m_tuser, m_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[0] !== want.done) begin
					$error("frame_done: expected %0d, got %0d", want.done, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== want.err) begin
					$error("frame_error: expected %0d, got %0d", want.err, m_tuser[1]);
					errors++;
				end
				if (m_tdata[7:0] !== want.len) begin
					$error("message_length: expected %0d, got %0d", want.len, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[15:8] !== want.rdata) begin
					$error("read_data: expected %h, got %h", want.rdata, m_tdata[15:8]);
					errors++;
				end
				if (m_tdata[16] !== want.link) begin
					$error("link_ok: expected %0d, got %0d", want.link, m_tdata[16]);
					errors++;
				end
			end
		end
	end

	initial begin
		byte_t phase_limit [PHASES];
		int start;
		int pick;
		for (int i = 0; i < RING_DEPTH; i++)
			ring[i] = 8'd0;
		for (int i = 0; i < MSG_DEPTH; i++)
			msg[i] = 8'd0;
		wpos = 0;
		msg_len = 0;
		limit = LIMIT_RESET;
		idle_ticks = LIMIT_RESET;
		link_flag = 1'b0;
		phase_limit = '{8'd1, 8'd255, 8'd0, LIMIT_RESET, 8'd255, 8'd1, 8'd0, 8'd0};
		for (int p = 0; p < PHASES; p++)
			if (phase_limit[p] == 8'd0)
				phase_limit[p] = byte_t'($urandom_range(2, 254));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		stall_pct = 13;
		foreach (directed[i])
			send_word(directed[i].act, directed[i].data, directed[i].idx, directed[i].typed,
				directed[i].want);
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 82; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 82; end
				default: begin send_idle_pct = 13; stall_pct = 13; end
			endcase
			write_limit(phase_limit[p]);
			// walk the idle counter all the way up once at the widest limit
			if (phase_limit[p] == 8'd255 && !long_burst_done) begin
				long_burst_done = 1;
				send_word(ACT_BYTE, byte_t'($urandom_range(255)), 7'd0);
				repeat (257)
					send_word(ACT_TICK, byte_t'($urandom_range(255)), 7'($urandom_range(127)));
			end
			start = words_sent;
			while (words_sent - start < WORDS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 55)
					send_random_frame();
				else if (pick < 70)
					repeat ($urandom_range(1, 14))
						send_word(ACT_TICK, byte_t'($urandom_range(255)),
							7'($urandom_range(127)));
				else if (pick < 88)
					repeat ($urandom_range(1, 4))
						send_word(ACT_READ, byte_t'($urandom_range(255)),
							7'($urandom_range(127)));
				else if (pick < 93)
					send_word(ACT_NONE, byte_t'($urandom_range(255)), 7'($urandom_range(127)));
				else
					send_word(ACT_BYTE, byte_t'($urandom_range(255)), 7'd0);
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			errors++;
		end
		$display("Ran %0d words over %0d timeout settings and four handshake idling mixes.",
			words_sent, PHASES + 1);
		$display("Parsed %0d frames (%0d flagged as bad or clamped), saw %0d link drops.",
			frames_parsed, frames_flagged, link_drops);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: radio_frame_receiver.f
design/rfr_pkg.sv
design/rfr_ram.sv
design/radio_frame_receiver.sv
test/radio_frame_receiver_test.sv
